@@ hdl/hcbp_pkg.sv @@
// shared types and constants for the huffman code bit packer
// no dependencies; imported by the top level
package hcbp_pkg;

   localparam int OP_W    = 2;   // request opcode width
   localparam int SYM_W   = 8;   // symbol / table index width
   localparam int VALUE_W = 64;  // code value field width
   localparam int LEN_W   = 7;   // code length field width
   localparam int BYTE_W  = 8;   // packed output byte width

   typedef enum logic [OP_W-1:0] {
      OP_WRITE  = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FLUSH  = 2'd2
   } op_type;

endpackage

@@ hdl/huffman_code_bit_packer.sv @@
// huffman encoder back end: code table and msb-first bit packer
// depends on hcbp_pkg and hcbp_ram
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  req     | in        | req_valid/stall    | req_op, req_symbol, req_code_value, req_code_length
//  rsp     | out       | rsp_valid/stall    | rsp_out_byte, rsp_last
//
// one request transaction per cycle while req_stall is low; an encode that completes full bytes
// holds the request side until they have left, one byte a cycle while rsp_stall is low
// path: table read, then merge into the accumulator, then the byte register
// reset (synchronous, active high) clears the per-entry valid bits, so every symbol
// reads as absent; the table ram itself is not swept
// rsp_stall backs up through the accumulator and the lookup stage to req_stall
module huffman_code_bit_packer #(
   parameter int SYMBOL_COUNT  = 256,
   parameter int MAX_CODE_BITS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [hcbp_pkg::OP_W-1:0]    req_op,
   input  logic [hcbp_pkg::SYM_W-1:0]   req_symbol,
   input  logic [hcbp_pkg::VALUE_W-1:0] req_code_value,
   input  logic [hcbp_pkg::LEN_W-1:0]   req_code_length,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [hcbp_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                         rsp_last
);

   import hcbp_pkg::*;

   localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
   localparam int ENTRY_W = MAX_CODE_BITS + LEN_W;
   // accumulator: up to seven leftover bits plus one full code, msb aligned
   localparam int ACC_W   = MAX_CODE_BITS + BYTE_W - 1;
   localparam int CNT_W   = $clog2(ACC_W + 1);

   // ---------------- request decode ----------------
   logic              req_take;
   logic              sym_in_range;
   logic              tbl_wr;
   logic              tbl_rd;
   logic              flush_req;
   logic [ADDR_W-1:0] addr;
   logic [LEN_W-1:0]  len_sat;
   logic [ENTRY_W-1:0] wr_entry;
   logic [ENTRY_W-1:0] rd_entry;

   assign req_take     = req_valid && !req_stall;
   assign sym_in_range = {1'b0, req_symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
   assign addr         = req_symbol[ADDR_W-1:0];

   // overlong lengths saturate, code bits above the max width are dropped
   assign len_sat  = (req_code_length > LEN_W'(MAX_CODE_BITS)) ?
                     LEN_W'(MAX_CODE_BITS) : req_code_length;
   assign wr_entry = {req_code_value[MAX_CODE_BITS-1:0], len_sat};

   always_comb begin
      tbl_wr    = 1'b0;
      tbl_rd    = 1'b0;
      flush_req = 1'b0;
      case (req_op)
         OP_WRITE:  tbl_wr    = req_take && sym_in_range;
         OP_ENCODE: tbl_rd    = req_take && sym_in_range;
         OP_FLUSH:  flush_req = req_take;
         default:   ;  // unused opcode is dropped
      endcase
   end

   // ---------------- code table ----------------
   logic [SYMBOL_COUNT-1:0] tbl_valid_ff, tbl_valid_in;

   hcbp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SYMBOL_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr),
      .wr_addr (addr),
      .wr_data (wr_entry),
      .rd_en   (tbl_rd),
      .rd_addr (addr),
      .rd_data (rd_entry)
   );

   always_comb begin
      tbl_valid_in = tbl_valid_ff;
      if (tbl_wr) begin
         tbl_valid_in[addr] = 1'b1;
      end
   end

   // ---------------- lookup stage ----------------
   // holds an encode or flush while the ram output stays put (read only on accept)
   logic s1_valid_ff, s1_valid_in;
   logic s1_flush_ff, s1_flush_in;
   logic s1_hit_ff,   s1_hit_in;
   logic s1_load;
   logic s1_take;

   assign s1_load   = tbl_rd || flush_req;
   assign req_stall = s1_valid_ff && !s1_take;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_flush_in = s1_flush_ff;
      s1_hit_in   = s1_hit_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
         s1_flush_in = flush_req;
         s1_hit_in   = tbl_valid_ff[addr];
      end else if (s1_take) begin
         s1_valid_in = 1'b0;
      end
   end

   // ---------------- accumulator ----------------
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]        rsp_byte_ff, rsp_byte_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     out_free;
   logic                     emit_full;
   logic                     enc_take;
   logic                     flush_take;
   logic                     flush_emit;
   logic                     out_load;
   logic [LEN_W-1:0]         code_len;
   logic [CNT_W-1:0]         enc_len;
   logic [MAX_CODE_BITS-1:0] code_bits;
   logic [ACC_W-1:0]         base_acc;
   logic [CNT_W-1:0]         base_cnt;
   logic [CNT_W-1:0]         shamt;
   logic [ACC_W-1:0]         merged;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // absent or never-written symbols count as zero length
   assign code_len  = s1_hit_ff ? rd_entry[LEN_W-1:0] : '0;
   assign enc_len   = CNT_W'(code_len);
   assign code_bits = rd_entry[ENTRY_W-1 -: MAX_CODE_BITS]
                      & ~({MAX_CODE_BITS{1'b1}} << code_len);

   // a full byte leaves the top of the accumulator when the output register frees up
   assign emit_full = (cnt_ff >= CNT_W'(BYTE_W)) && out_free;
   assign base_acc  = emit_full ? (acc_ff << BYTE_W) : acc_ff;
   assign base_cnt  = emit_full ? (cnt_ff - CNT_W'(BYTE_W)) : cnt_ff;

   // an encode merges once no full byte is left, even in the cycle the last one leaves
   assign enc_take   = s1_valid_ff && !s1_flush_ff && (base_cnt < CNT_W'(BYTE_W));
   // flush waits for the accumulator to drain, and for the output when bits are pending
   assign flush_take = s1_valid_ff && s1_flush_ff && (cnt_ff < CNT_W'(BYTE_W))
                       && ((cnt_ff == '0) || out_free);
   assign flush_emit = flush_take && (cnt_ff != '0);
   assign s1_take    = enc_take || flush_take;

   // new code lands right below the bits already waiting
   assign shamt  = CNT_W'(ACC_W) - base_cnt - enc_len;
   assign merged = base_acc
                   | ({{(ACC_W - MAX_CODE_BITS){1'b0}}, code_bits} << shamt);

   always_comb begin
      acc_in = base_acc;
      cnt_in = base_cnt;
      if (enc_take) begin
         acc_in = merged;
         cnt_in = base_cnt + enc_len;
      end else if (flush_emit) begin
         acc_in = '0;
         cnt_in = '0;
      end
   end

   // ---------------- output register ----------------
   assign out_load = emit_full || flush_emit;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         // low bits below the count are zero, so a flush byte is already padded
         rsp_byte_in  = acc_ff[ACC_W-1 -: BYTE_W];
         // last byte of an encode: fewer than a byte stays behind
         rsp_last_in  = flush_emit
                        || ({1'b0, cnt_ff} < (CNT_W + 1)'(2 * BYTE_W));
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_valid_ff <= '0;
         s1_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tbl_valid_ff <= tbl_valid_in;
         s1_valid_ff  <= s1_valid_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      s1_flush_ff <= s1_flush_in;
      s1_hit_ff   <= s1_hit_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   // ---------------- assertions ----------------
   // bits below the pending count are always clear
   a_acc_clean: assert property (@(posedge clock) disable iff (reset)
      (acc_ff << cnt_ff) == '0)
      else $error("accumulator holds bits below the pending count");

   // a byte that is not last leaves at least one more full byte behind
   a_more_bytes: assert property (@(posedge clock) disable iff (reset)
      (out_load && !rsp_last_in) |=> (cnt_ff >= CNT_W'(BYTE_W)))
      else $error("non-last byte emitted without a following byte");

   // a new request only lands in the lookup stage when the old one moves on
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_take && s1_valid_ff) |-> s1_take)
      else $error("lookup stage overwritten");

   // a flush never leaves pending bits behind
   a_flush_drains: assert property (@(posedge clock) disable iff (reset)
      flush_take |=> (cnt_ff == '0))
      else $error("flush left pending bits");

endmodule

@@ hdl/hcbp_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
// no dependencies; used for the code table
module hcbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

@@ tb/huffman_packer_checker.sv @@
// checker for the huffman code bit packer: watches both channels, predicts the
// packed bytes and compares them in order; depends on hcbp_pkg only
`timescale 1ns / 1ps

module huffman_packer_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [hcbp_pkg::OP_W-1:0]    req_op,
   input  logic [hcbp_pkg::SYM_W-1:0]   req_symbol,
   input  logic [hcbp_pkg::VALUE_W-1:0] req_code_value,
   input  logic [hcbp_pkg::LEN_W-1:0]   req_code_length,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [hcbp_pkg::BYTE_W-1:0]  rsp_out_byte,
   input  logic                         rsp_last,
   output int                           mismatch_count,
   output int                           bytes_outstanding,
   output int                           bytes_checked
);

   localparam int SYMBOL_COUNT  = 256;
   localparam int MAX_CODE_BITS = 64;

   typedef struct {
      logic [hcbp_pkg::BYTE_W-1:0] data;
      logic                        last;
   } packed_byte_type;

   logic [hcbp_pkg::VALUE_W-1:0] code_bits_table [SYMBOL_COUNT];
   logic [hcbp_pkg::LEN_W-1:0]   code_len_table  [SYMBOL_COUNT];
   logic [hcbp_pkg::BYTE_W-1:0]  bit_acc;
   int                           acc_count;
   packed_byte_type              expected_bytes [$];

   initial begin
      mismatch_count    = 0;
      bytes_outstanding = 0;
      bytes_checked     = 0;
   end

   task automatic store_code(input logic [7:0] sym, input logic [63:0] value,
                             input logic [6:0] len);
      logic [6:0] clipped;
      clipped = (len > MAX_CODE_BITS) ? 7'(MAX_CODE_BITS) : len;
      code_bits_table[sym] = value;
      code_len_table[sym]  = clipped;
   endtask

   // shift the code msb first into the accumulator, emitting each full byte
   task automatic pack_symbol(input logic [7:0] sym);
      logic [63:0]     code;
      int              clen;
      int              emitted;
      packed_byte_type pb;
      code    = code_bits_table[sym];
      clen    = code_len_table[sym];
      emitted = 0;
      for (int i = 0; i < clen; i++) begin
         bit_acc = {bit_acc[6:0], code[clen-1-i]};
         acc_count++;
         if (acc_count == 8) begin
            pb.data = bit_acc;
            pb.last = 1'b0;
            expected_bytes.insert(expected_bytes.size(), pb);
            emitted++;
            bit_acc   = '0;
            acc_count = 0;
         end
      end
      if (emitted > 0)
         expected_bytes[expected_bytes.size()-1].last = 1'b1;
   endtask

   task automatic flush_pending();
      packed_byte_type pb;
      if (acc_count != 0) begin
         pb.data = bit_acc << (8 - acc_count);
         pb.last = 1'b1;
         expected_bytes.insert(expected_bytes.size(), pb);
         bit_acc   = '0;
         acc_count = 0;
      end
   endtask

   task automatic check_byte(input logic [7:0] data, input logic last);
      packed_byte_type want;
      if (expected_bytes.size() == 0) begin
         $display("%0t: out_byte expected none actual %02h last %0b", $time, data, last);
         mismatch_count++;
      end else begin
         want = expected_bytes.pop_front();
         if (data !== want.data) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, want.data, data);
            mismatch_count++;
         end
         if (last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, last);
            mismatch_count++;
         end
      end
      bytes_checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SYMBOL_COUNT; s++) begin
            code_bits_table[s] = '0;
            code_len_table[s]  = '0;
         end
         bit_acc   = '0;
         acc_count = 0;
         expected_bytes.delete();
      end else begin
         if (req_valid && !req_stall) begin
            case (req_op)
               hcbp_pkg::OP_WRITE:  store_code(req_symbol, req_code_value, req_code_length);
               hcbp_pkg::OP_ENCODE: pack_symbol(req_symbol);
               hcbp_pkg::OP_FLUSH:  flush_pending();
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall)
            check_byte(rsp_out_byte, rsp_last);
      end
      bytes_outstanding = expected_bytes.size();
   end

endmodule

@@ tb/testbench.sv @@
// top of the huffman code bit packer testbench: clock, reset, request stimulus,
// response backpressure and verdict; depends on hcbp_pkg and huffman_packer_checker
`timescale 1ns / 1ps

module testbench;

   // op 3 is not decoded by the block, it must be dropped silently
   localparam logic [hcbp_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 450;
   localparam int LONG_HOLD    = 300;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [hcbp_pkg::OP_W-1:0]    req_op;
   logic [hcbp_pkg::SYM_W-1:0]   req_symbol;
   logic [hcbp_pkg::VALUE_W-1:0] req_code_value;
   logic [hcbp_pkg::LEN_W-1:0]   req_code_length;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [hcbp_pkg::BYTE_W-1:0]  rsp_out_byte;
   logic                         rsp_last;

   int mismatch_count;
   int bytes_outstanding;
   int bytes_checked;

   // transaction tallies for the closing summary
   int n_writes   = 0;
   int n_encodes  = 0;
   int n_flushes  = 0;
   int n_unused   = 0;

   // idling control shared between the stimulus and the receiver
   bit sender_calm   = 0;
   bit receiver_calm = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   // symbols that hold a written code, so encodes mostly hit real entries
   bit            known_sym [256];
   logic [7:0]    code_syms [$];

   huffman_code_bit_packer u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_symbol      (req_symbol),
      .req_code_value  (req_code_value),
      .req_code_length (req_code_length),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last)
   );

   huffman_packer_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_symbol        (req_symbol),
      .req_code_value    (req_code_value),
      .req_code_length   (req_code_length),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last          (rsp_last),
      .mismatch_count    (mismatch_count),
      .bytes_outstanding (bytes_outstanding),
      .bytes_checked     (bytes_checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver: random stalls, calm stretch, and long hold-offs counted here
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (receiver_calm) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 20);
         end
      end
   end

   // offer one transaction, with random idle cycles ahead of it, and wait until taken
   task automatic send_request(input logic [1:0] op, input logic [7:0] sym,
                               input logic [63:0] value, input logic [6:0] len);
      while (!sender_calm && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_symbol      <= sym;
      req_code_value  <= value;
      req_code_length <= len;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      case (op)
         hcbp_pkg::OP_WRITE: begin
            n_writes++;
            if (len != 0 && !known_sym[sym]) begin
               known_sym[sym] = 1'b1;
               code_syms.insert(code_syms.size(), sym);
            end
         end
         hcbp_pkg::OP_ENCODE: n_encodes++;
         hcbp_pkg::OP_FLUSH:  n_flushes++;
         default:             n_unused++;
      endcase
   endtask

   // mostly short codes, some long, a few overlong or absent
   function automatic logic [6:0] pick_code_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)      return 7'($urandom_range(1, 8));
      else if (r < 85) return 7'($urandom_range(9, 20));
      else if (r < 95) return 7'($urandom_range(21, 64));
      else if (r < 98) return 7'($urandom_range(65, 127));
      else             return 7'd0;
   endfunction

   task automatic write_random_code();
      send_request(hcbp_pkg::OP_WRITE, 8'($urandom_range(0, 255)),
                   {$urandom, $urandom}, pick_code_length());
   endtask

   task automatic run_random_traffic(input int count);
      int         r;
      logic [7:0] sym;
      // load a starting alphabet so the encodes have codes to pack
      for (int i = 0; i < 24; i++)
         write_random_code();
      for (int i = 24; i < count; i++) begin
         // long hold-off on the response side while requests keep coming
         if (i == 100)
            hold_requests++;
         sender_calm   = (i >= 250 && i < 350);
         receiver_calm = (i >= 250 && i < 350);
         r = $urandom_range(0, 99);
         if (r < 12) begin
            write_random_code();
         end else if (r < 90) begin
            if (code_syms.size() != 0 && $urandom_range(0, 99) < 85)
               sym = code_syms[$urandom_range(0, code_syms.size() - 1)];
            else
               sym = 8'($urandom_range(0, 255));
            send_request(hcbp_pkg::OP_ENCODE, sym, {$urandom, $urandom},
                         7'($urandom_range(0, 127)));
         end else if (r < 98) begin
            send_request(hcbp_pkg::OP_FLUSH, 8'($urandom_range(0, 255)),
                         {$urandom, $urandom}, 7'($urandom_range(0, 127)));
         end else begin
            send_request(OP_UNUSED, 8'($urandom_range(0, 255)),
                         {$urandom, $urandom}, 7'($urandom_range(0, 127)));
         end
      end
      sender_calm   = 0;
      receiver_calm = 0;
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_op          = hcbp_pkg::OP_WRITE;
      req_symbol      = '0;
      req_code_value  = '0;
      req_code_length = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part
      // empty table: every symbol absent, so nothing comes out
      send_request(hcbp_pkg::OP_ENCODE, 8'd0, '0, '0);
      send_request(hcbp_pkg::OP_ENCODE, 8'd255, '1, '1);
      // flush with nothing pending
      send_request(hcbp_pkg::OP_FLUSH, 8'd0, '0, '0);
      // unused opcode with all payload bits high
      send_request(OP_UNUSED, 8'd255, '1, '1);
      send_request(hcbp_pkg::OP_WRITE, 8'd255, '1, 7'd64);
      send_request(hcbp_pkg::OP_WRITE, 8'd0, '0, 7'd1);
      send_request(hcbp_pkg::OP_WRITE, 8'd1, 64'h5, 7'd3);
      // overlong length saturates to the full code width
      send_request(hcbp_pkg::OP_WRITE, 8'd2, '1, 7'd127);
      // zero length gives the symbol an empty code even with code bits present
      send_request(hcbp_pkg::OP_WRITE, 8'd3, 64'hA5A5_A5A5_A5A5_A5A5, 7'd0);
      send_request(hcbp_pkg::OP_WRITE, 8'd4, 64'h8000_0000_0000_0000, 7'd64);
      // eight full bytes from one encode, aligned and then unaligned
      send_request(hcbp_pkg::OP_ENCODE, 8'd255, '0, '0);
      send_request(hcbp_pkg::OP_ENCODE, 8'd1, '0, '0);
      send_request(hcbp_pkg::OP_ENCODE, 8'd255, '0, '0);
      send_request(hcbp_pkg::OP_ENCODE, 8'd0, '0, '0);
      send_request(hcbp_pkg::OP_ENCODE, 8'd3, '0, '0);
      send_request(hcbp_pkg::OP_FLUSH, 8'd0, '0, '0);
      send_request(hcbp_pkg::OP_ENCODE, 8'd4, '0, '0);
      send_request(hcbp_pkg::OP_ENCODE, 8'd2, '0, '0);
      send_request(hcbp_pkg::OP_FLUSH, 8'd0, '0, '0);
      send_request(hcbp_pkg::OP_ENCODE, 8'd1, '0, '0);
      send_request(hcbp_pkg::OP_ENCODE, 8'd0, '0, '0);
      send_request(hcbp_pkg::OP_FLUSH, 8'd255, '1, '1);
      // a single one-bit code then flush: lone bit lands in the msb
      send_request(hcbp_pkg::OP_WRITE, 8'd0, 64'h1, 7'd1);
      send_request(hcbp_pkg::OP_ENCODE, 8'd0, '0, '0);
      send_request(hcbp_pkg::OP_FLUSH, 8'd0, '0, '0);

      run_random_traffic(RANDOM_ITEMS);

      // drain: let the checker see the last transaction, then wait out the pipeline
      req_valid <= 1'b0;
      @(posedge clock);
      while (bytes_outstanding != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      $display("covered %0d table writes, %0d encodes, %0d flushes, %0d unused opcodes",
               n_writes, n_encodes, n_flushes, n_unused);
      $display("%0d packed bytes checked, %0d mismatches", bytes_checked, mismatch_count);
      if (mismatch_count == 0 && bytes_outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // run limit, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("timeout with %0d bytes still expected", bytes_outstanding);
      $display("TEST FAILED");
      $finish;
   end

endmodule
